// ----- hw/rtl/line_edit_buffer_macros.svh -----
// ---------------------------------------------------------------------------
// line_edit_buffer_macros: assertion macros for the line edit buffer
// Each macro expects clk and rst to be visible in the using module.
// ---------------------------------------------------------------------------
`ifndef LINE_EDIT_BUFFER_MACROS_SVH
`define LINE_EDIT_BUFFER_MACROS_SVH

// same-cycle implication, idle during reset
`define LEB_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("line edit buffer: same-cycle check failed");

// next-cycle implication, idle during reset
`define LEB_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("line edit buffer: next-cycle check failed");

`endif

// ----- hw/rtl/leb_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// leb_pkg: shared types and constants for the line edit buffer
// Opcodes, fixed field widths and the per-cell control word.
// ---------------------------------------------------------------------------
package leb_pkg;

  // fixed field widths
  localparam int OPCODE_W = 3;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 10;
  localparam int RIDX_W   = 8;
  localparam int LENF_W   = 9;

  // default line capacity in bytes
  localparam int DEF_MAX_LEN = 256;

  // cells per first-level group of the read tree
  localparam int GRP_SIZE = 16;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_BACKSPACE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_MOVE      = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SETCUR    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_FINISH    = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RESTART   = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_READ      = 3'd7;

  // shift command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a gap at the cursor, write the new byte
    logic bs;   // close the gap left of the cursor
  } leb_cell_ctl_t;

endpackage

// ----- hw/rtl/leb_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// leb_if: command and response channels of the line edit buffer
// Valid/ready channels; a word moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface leb_cmd_if;
  import leb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OPCODE_W-1:0]      opcode;
  logic [CHAR_W-1:0]        char_in;
  logic signed [POS_W-1:0]  position;
  logic [RIDX_W-1:0]        read_index;

  modport source (output valid, opcode, char_in, position, read_index, input ready);
  modport sink (input valid, opcode, char_in, position, read_index, output ready);
endinterface

interface leb_rsp_if;
  import leb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] read_char;
  logic [LENF_W-1:0] text_length;
  logic [LENF_W-1:0] cursor_pos;
  logic              ended;
  logic              accepted;

  modport source (output valid, read_char, text_length, cursor_pos, ended, accepted,
                  input ready);
  modport sink (input valid, read_char, text_length, cursor_pos, ended, accepted,
                output ready);
endinterface

// ----- hw/rtl/leb_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// leb_cell: one character cell of the line
// Holds one byte; shifts right on insert, left on backspace, and drives its
// byte onto the read tree when its index is addressed.
// ---------------------------------------------------------------------------
module leb_cell #(
  parameter int LEN_W = 9,
  parameter int IDX_W = 9,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  leb_pkg::leb_cell_ctl_t        ctl,
  input  logic [LEN_W-1:0]              cursor,
  input  logic [IDX_W-1:0]              ridx,
  input  logic [leb_pkg::CHAR_W-1:0]    ch,
  input  logic [leb_pkg::CHAR_W-1:0]    left,
  input  logic [leb_pkg::CHAR_W-1:0]    right,
  output logic [leb_pkg::CHAR_W-1:0]    data,
  output logic [leb_pkg::CHAR_W-1:0]    rd
);
  import leb_pkg::*;

  localparam logic [LEN_W:0] MY_IDX  = (LEN_W + 1)'(IDX);
  localparam logic [LEN_W:0] MY_NEXT = (LEN_W + 1)'(IDX + 1);
  localparam logic [IDX_W-1:0] MY_RIDX = IDX_W'(IDX);

  logic [LEN_W:0] cur_x;

  assign cur_x = {1'b0, cursor};

  // byte update
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (MY_IDX > cur_x) begin
        data <= left;
      end else if (MY_IDX == cur_x) begin
        data <= ch;
      end
    end else if (ctl.bs) begin
      if (MY_NEXT >= cur_x) begin
        data <= right;
      end
    end
  end

  // read tap: zero unless addressed
  assign rd = (ridx == MY_RIDX) ? data : '0;

endmodule

// ----- hw/rtl/leb_mod_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// leb_mod_unit: bit-serial remainder
// Restoring division, one dividend bit per cycle; gives dividend mod divisor.
// ---------------------------------------------------------------------------
`include "line_edit_buffer_macros.svh"

module leb_mod_unit #(
  parameter int P_W = 9,
  parameter int D_W = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [P_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [D_W-1:0] rem
);
  import leb_pkg::*;

  localparam int CNT_W = $clog2(P_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [P_W-1:0]   quo_sh;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   div_r;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;

  // bring down the next dividend bit, subtract when it fits
  assign trial = {rem_r, quo_sh[P_W-1]};
  assign diff  = trial - {1'b0, div_r};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(P_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy) begin
      quo_sh <= quo_sh << 1;
      if (trial >= {1'b0, div_r}) begin
        rem_r <= diff[D_W-1:0];
      end else begin
        rem_r <= trial[D_W-1:0];
      end
    end
  end

  assign rem = rem_r;

  `LEB_ASSERT_IMP(a_rem_below_div, busy || done, rem_r < div_r)
  `LEB_ASSERT_NEXT(a_done_single, done, !done && !busy)
  `LEB_ASSERT_IMP(a_cnt_live, busy, cnt != '0)

endmodule

// ----- hw/rtl/line_edit_buffer.sv -----
`timescale 1ns / 1ps
// After a command is accepted the sequencer steps through EXEC and then DONE, where
// the response register loads once its slot is free; read adds READ after EXEC (two-level
// registered read tree) and set cursor adds MOD, which waits on the bit-serial remainder
// unit. One command is in flight at a time; the next can be accepted while the previous
// response waits.
// Reset clears length, cursor, ended flag and handshake state, not the cells.
// ---------------------------------------------------------------------------
// line_edit_buffer: one-line text edit buffer with a cursor
// A row of byte cells shifts the tail on insert and backspace; a small
// sequencer handles cursor moves, wrap-around and reads.
// ---------------------------------------------------------------------------
`include "line_edit_buffer_macros.svh"

module line_edit_buffer #(
  parameter int MAX_LEN = leb_pkg::DEF_MAX_LEN
) (
  input logic       clk,
  input logic       rst,
  leb_cmd_if.sink   cmd,
  leb_rsp_if.source rsp
);
  import leb_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (LEN_W > RIDX_W) ? LEN_W : RIDX_W;
  localparam int P_W   = (LEN_W > 9) ? LEN_W : 9;
  localparam int D_W   = LEN_W + 1;
  localparam int S_W   = ((LEN_W > POS_W) ? LEN_W : POS_W) + 2;
  localparam int NGRP  = (MAX_LEN + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_LEN);
  localparam logic signed [S_W-1:0] ONE_S = S_W'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]              state;
  logic [OPCODE_W-1:0]     op_r;
  logic [CHAR_W-1:0]       ch_r;
  logic signed [POS_W-1:0] pos_r;
  logic [RIDX_W-1:0]       ridx_r;

  logic [LEN_W-1:0]        len;
  logic [LEN_W-1:0]        cursor;
  logic                    ended;
  logic                    acc_r;
  logic [CHAR_W-1:0]       rchar_r;

  logic                    rsp_valid;
  logic [CHAR_W-1:0]       rsp_char;
  logic [LENF_W-1:0]       rsp_len;
  logic [LENF_W-1:0]       rsp_cur;
  logic                    rsp_ended;
  logic                    rsp_acc;

  leb_cell_ctl_t           cell_ctl;
  logic [IDX_W-1:0]        ridx_x;
  logic [CHAR_W-1:0]       cell_data [MAX_LEN];
  logic [CHAR_W-1:0]       cell_rd   [MAX_LEN];
  logic [CHAR_W-1:0]       grp_or    [NGRP];
  logic [CHAR_W-1:0]       grp_q     [NGRP];
  logic [CHAR_W-1:0]       rd_all;

  logic signed [S_W-1:0]   len_s;
  logic signed [S_W-1:0]   cur_s;
  logic signed [S_W-1:0]   pos_s;
  logic signed [S_W-1:0]   move_s;
  logic signed [S_W-1:0]   wrap_s;
  logic signed [S_W-1:0]   wrap_abs;
  logic                    full;
  logic                    move_ok;
  logic                    mod_start;
  logic [P_W-1:0]          mod_dividend;
  logic [D_W-1:0]          mod_divisor;
  logic                    mod_done;
  logic [D_W-1:0]          mod_rem;
  logic                    rsp_load;

  assign cmd.ready = (state == S_IDLE);

  // cell row control
  assign full   = (len == FULL_LEN);
  assign ridx_x = IDX_W'(ridx_r);

  always_comb begin
    cell_ctl.ins = (state == S_EXEC) && (op_r == OP_INSERT) && !full;
    cell_ctl.bs  = (state == S_EXEC) && (op_r == OP_BACKSPACE) && (cursor != '0);
  end

  // character cells, chained left to right
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic [CHAR_W-1:0] left_b;
    logic [CHAR_W-1:0] right_b;

    if (i == 0) begin : g_first
      assign left_b = '0;
    end else begin : g_mid_l
      assign left_b = cell_data[i-1];
    end
    if (i == MAX_LEN - 1) begin : g_last
      assign right_b = '0;
    end else begin : g_mid_r
      assign right_b = cell_data[i+1];
    end

    leb_cell #(
      .LEN_W (LEN_W),
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk    (clk),
      .ctl    (cell_ctl),
      .cursor (cursor),
      .ridx   (ridx_x),
      .ch     (ch_r),
      .left   (left_b),
      .right  (right_b),
      .data   (cell_data[i]),
      .rd     (cell_rd[i])
    );
  end

  // read tree, first level: OR within each group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < MAX_LEN) begin
          grp_or[g] = grp_or[g] | cell_rd[g * GRP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_q[g] <= grp_or[g];
      end
    end
  end

  // read tree, second level
  always_comb begin
    rd_all = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_all = rd_all | grp_q[g];
    end
  end

  // signed cursor arithmetic
  assign len_s    = S_W'(len);
  assign cur_s    = S_W'(cursor);
  assign pos_s    = S_W'(pos_r);
  assign move_s   = cur_s + pos_s;
  assign move_ok  = !move_s[S_W-1] && (move_s <= len_s);
  assign wrap_s   = len_s + pos_s + ONE_S;
  assign wrap_abs = wrap_s[S_W-1] ? -wrap_s : wrap_s;

  // remainder unit for set cursor
  assign mod_start    = (state == S_EXEC) && (op_r == OP_SETCUR);
  assign mod_dividend = pos_r[POS_W-1] ? P_W'(wrap_abs) : P_W'(pos_r[POS_W-2:0]);
  assign mod_divisor  = {1'b0, len} + D_W'(1);

  leb_mod_unit #(
    .P_W (P_W),
    .D_W (D_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // response slot free or draining this cycle
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp.ready);

  // sequencer and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      len    <= '0;
      cursor <= '0;
      ended  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          unique case (op_r)
            OP_INSERT: begin
              if (!full) begin
                len    <= len + LEN_W'(1);
                cursor <= cursor + LEN_W'(1);
              end
            end
            OP_BACKSPACE: begin
              if (cursor != '0) begin
                len    <= len - LEN_W'(1);
                cursor <= cursor - LEN_W'(1);
              end
            end
            OP_MOVE: begin
              if (move_ok) begin
                cursor <= move_s[LEN_W-1:0];
              end
            end
            OP_SETCUR: begin
              state <= S_MOD;
            end
            OP_CLEAR: begin
              len    <= '0;
              cursor <= '0;
            end
            OP_FINISH: begin
              ended <= 1'b1;
            end
            OP_RESTART: begin
              ended <= 1'b0;
            end
            OP_READ: begin
              state <= S_READ;
            end
          endcase
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_MOD: begin
          if (mod_done) begin
            cursor <= mod_rem[LEN_W-1:0];
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // command capture, accept flag and read byte
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_r    <= cmd.opcode;
      ch_r    <= cmd.char_in;
      pos_r   <= cmd.position;
      ridx_r  <= cmd.read_index;
      rchar_r <= '0;
    end
    if (state == S_EXEC) begin
      case (op_r)
        OP_INSERT:    acc_r <= !full;
        OP_BACKSPACE: acc_r <= (cursor != '0);
        OP_MOVE:      acc_r <= move_ok;
        default:      acc_r <= 1'b1;
      endcase
    end
    if (state == S_READ) begin
      rchar_r <= ({1'b0, ridx_x} < (IDX_W + 1)'(len)) ? rd_all : '0;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_char  <= rchar_r;
      rsp_len   <= LENF_W'(len);
      rsp_cur   <= LENF_W'(cursor);
      rsp_ended <= ended;
      rsp_acc   <= acc_r;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.read_char   = rsp_char;
  assign rsp.text_length = rsp_len;
  assign rsp.cursor_pos  = rsp_cur;
  assign rsp.ended       = rsp_ended;
  assign rsp.accepted    = rsp_acc;

  `LEB_ASSERT_IMP(a_cursor_in_line, 1'b1, cursor <= len)
  `LEB_ASSERT_IMP(a_len_bound, 1'b1, len <= FULL_LEN)
  `LEB_ASSERT_NEXT(a_insert_grows, cell_ctl.ins, len == $past(len) + LEN_W'(1))

endmodule
